FILE: src/sdm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stereo disparity matcher.
// No dependencies.
package sdm_pkg;

	typedef struct packed {
		logic       frame_start;
		logic [7:0] right_c2;
		logic [7:0] right_c1;
		logic [7:0] right_c0;
		logic [7:0] left_c2;
		logic [7:0] left_c1;
		logic [7:0] left_c0;
	} pix_t;

	typedef struct packed {
		logic [7:0] disparity_level;
		logic [4:0] disp_idx;
	} res_t;

	typedef struct packed {
		logic [10:0] image_width;
		logic [5:0]  disp_range;
		logic [7:0]  penalty_small;
		logic [7:0]  penalty_large;
		logic [1:0]  channel_count;
	} cfg_t;

	localparam int CNT_W     = 7;
	localparam int COST_W    = 10;
	localparam int PATH_W    = 11;
	localparam int CH_MAX    = 3;
	localparam int DIV_STEPS = 8;
	localparam int ADDR_W    = 5;

	typedef struct packed {
		logic             accept;
		logic             scan;
		logic             agg;
		logic             div;
		logic             commit;
		logic             out_load;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] rng;
	} sts_t;

	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_DISP_RANGE    = 3'd1;
	localparam logic [2:0] REG_PENALTY_SMALL = 3'd2;
	localparam logic [2:0] REG_PENALTY_LARGE = 3'd3;
	localparam logic [2:0] REG_CHANNEL_COUNT = 3'd4;

	localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd1024;
	localparam logic [5:0]  RST_DISP_RANGE    = 6'd25;
	localparam logic [7:0]  RST_PENALTY_SMALL = 8'd10;
	localparam logic [7:0]  RST_PENALTY_LARGE = 8'd120;
	localparam logic [1:0]  RST_CHANNEL_COUNT = 2'd3;

	localparam logic [7:0]  PIX_FULL = 8'd255;

endpackage

FILE: src/sdm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sdm_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/sdm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the disparity matcher: scan, aggregate, divide, deliver.
// Depends on sdm_pkg.
module sdm_ctrl import sdm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	input  logic res_stall,
	input  sts_t sts,
	output logic pix_stall,
	output logic res_valid,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_AGG  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             res_valid_q;
	logic             agg_end;

	assign agg_end = (state_q == ST_AGG) && (cnt_q == sts.rng + CNT_W'(2));

	always_comb begin
		cmd          = '0;
		cmd.cnt      = cnt_q;
		cmd.accept   = (state_q == ST_IDLE) && pix_valid;
		cmd.scan     = (state_q == ST_SCAN);
		cmd.agg      = (state_q == ST_AGG);
		cmd.div      = (state_q == ST_DIV);
		cmd.commit   = agg_end;
		cmd.out_load = (state_q == ST_DONE) && (!res_valid_q || !res_stall);
	end

	assign pix_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (pix_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == sts.rng) begin
						state_q <= ST_AGG;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_AGG: begin
					if (agg_end) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS)) begin
						state_q <= ST_DONE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/sdm_datapath.sv
`timescale 1ns / 1ps
// Datapath: matching cost, neighbour path minima, best search, scaling divide.
// Depends on sdm_pkg and sdm_ram.
module sdm_datapath import sdm_pkg::*; #(
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_DISPARITY = 32,
	parameter int MAX_CHANNELS  = 3
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  pix_t pix,
	input  cmd_t cmd,
	output sts_t sts,
	output res_t res
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int DW    = $clog2(MAX_DISPARITY);
	localparam int HCH   = (MAX_CHANNELS > CH_MAX) ? CH_MAX : MAX_CHANNELS;
	localparam int NW    = DW + 8;
	localparam int CW2   = (XW > DW) ? XW : DW;
	localparam int DEPTH = MAX_WIDTH * (2 ** DW);

	logic [CNT_W-1:0] rng;
	logic [XW:0]      w_eff;
	logic [1:0]       nch;

	always_comb begin
		if (cfg.disp_range == '0) begin
			rng = CNT_W'(1);
		end else if (CNT_W'(cfg.disp_range) > CNT_W'(MAX_DISPARITY)) begin
			rng = CNT_W'(MAX_DISPARITY);
		end else begin
			rng = CNT_W'(cfg.disp_range);
		end
		if (cfg.image_width == '0) begin
			w_eff = (XW + 1)'(1);
		end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
			w_eff = (XW + 1)'(MAX_WIDTH);
		end else begin
			w_eff = (XW + 1)'(cfg.image_width);
		end
		if (cfg.channel_count == '0) begin
			nch = 2'd1;
		end else if (32'(cfg.channel_count) > HCH) begin
			nch = 2'(HCH);
		end else begin
			nch = cfg.channel_count;
		end
	end

	assign sts.rng = rng;

	logic [XW-1:0]    col_q;
	logic             first_q;
	logic [7:0]       lpix_q [CH_MAX];
	logic [7:0]       rpix_q [CH_MAX];
	logic [HCH-1:0][7:0] rh_q [MAX_DISPARITY-1];
	logic [COST_W-1:0] lcost_q [MAX_DISPARITY];

	logic [DW-1:0]     cnt_d;
	logic              issue;
	logic              rd_vld_s1;
	logic [DW-1:0]     rd_idx_s1;
	logic [COST_W-1:0] l_rd_s1;
	logic [COST_W-1:0] ram_rdata;

	assign cnt_d = cmd.cnt[DW-1:0];
	assign issue = (cmd.scan || cmd.agg) && (cmd.cnt < rng);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			col_q     <= '0;
			first_q   <= 1'b1;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.accept && pix.frame_start) begin
				col_q   <= '0;
				first_q <= 1'b1;
			end else if (cmd.commit) begin
				if ((XW + 1)'(col_q) + 1'b1 >= w_eff) begin
					col_q   <= '0;
					first_q <= 1'b0;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_d;
		l_rd_s1   <= lcost_q[cnt_d];
		if (cmd.accept) begin
			lpix_q[0] <= pix.left_c0;
			lpix_q[1] <= pix.left_c1;
			lpix_q[2] <= pix.left_c2;
			rpix_q[0] <= pix.right_c0;
			rpix_q[1] <= pix.right_c1;
			rpix_q[2] <= pix.right_c2;
		end
		if (cmd.commit) begin
			for (int c = 0; c < HCH; c++) begin
				rh_q[0][c] <= rpix_q[c];
			end
			for (int k = 1; k < MAX_DISPARITY - 1; k++) begin
				rh_q[k] <= rh_q[k-1];
			end
		end
	end

	// three smallest costs of the previous pixel and of the row above
	logic [COST_W-1:0] tv_q   [2][3];
	logic [DW-1:0]     ti_q   [2][3];
	logic              tvld_q [2][3];
	logic [COST_W-1:0] nv     [2];

	assign nv[0] = l_rd_s1;
	assign nv[1] = ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 2; s++) begin
				for (int k = 0; k < 3; k++) begin
					tvld_q[s][k] <= 1'b0;
				end
			end
		end else if (cmd.accept) begin
			for (int s = 0; s < 2; s++) begin
				for (int k = 0; k < 3; k++) begin
					tvld_q[s][k] <= 1'b0;
				end
			end
		end else if (cmd.scan && rd_vld_s1) begin
			for (int s = 0; s < 2; s++) begin
				if (!tvld_q[s][0] || nv[s] < tv_q[s][0]) begin
					tv_q[s][2] <= tv_q[s][1]; ti_q[s][2] <= ti_q[s][1];
					tvld_q[s][2] <= tvld_q[s][1];
					tv_q[s][1] <= tv_q[s][0]; ti_q[s][1] <= ti_q[s][0];
					tvld_q[s][1] <= tvld_q[s][0];
					tv_q[s][0] <= nv[s]; ti_q[s][0] <= rd_idx_s1;
					tvld_q[s][0] <= 1'b1;
				end else if (!tvld_q[s][1] || nv[s] < tv_q[s][1]) begin
					tv_q[s][2] <= tv_q[s][1]; ti_q[s][2] <= ti_q[s][1];
					tvld_q[s][2] <= tvld_q[s][1];
					tv_q[s][1] <= nv[s]; ti_q[s][1] <= rd_idx_s1;
					tvld_q[s][1] <= 1'b1;
				end else if (!tvld_q[s][2] || nv[s] < tv_q[s][2]) begin
					tv_q[s][2] <= nv[s]; ti_q[s][2] <= rd_idx_s1;
					tvld_q[s][2] <= 1'b1;
				end
			end
		end
	end

	// aggregation pass, disparity pd handled at cnt = pd + 2
	logic              proc;
	logic [DW-1:0]     pd;
	logic [COST_W-1:0] w0_q [2];
	logic [COST_W-1:0] w1_q [2];
	logic [COST_W-1:0] cost;
	logic [7:0]        rp   [CH_MAX];
	logic [PATH_W-1:0] path [2];
	logic [PATH_W-1:0] agg;

	assign proc = cmd.agg && (cmd.cnt >= CNT_W'(2)) && (cmd.cnt <= rng + CNT_W'(1));
	assign pd   = DW'(cmd.cnt - CNT_W'(2));

	always_comb begin
		for (int c = 0; c < CH_MAX; c++) begin
			rp[c] = rpix_q[c];
		end
		if (pd != '0) begin
			for (int c = 0; c < HCH; c++) begin
				rp[c] = rh_q[DW'(pd - 1'b1)][c];
			end
		end
		cost = '0;
		for (int c = 0; c < HCH; c++) begin
			if (c < 32'(nch)) begin
				if (CW2'(pd) <= CW2'(col_q)) begin
					cost = cost + COST_W'((lpix_q[c] > rp[c]) ?
						lpix_q[c] - rp[c] : rp[c] - lpix_q[c]);
				end else begin
					cost = cost + COST_W'(PIX_FULL);
				end
			end
		end
	end

	always_comb begin
		logic [DW:0]       p1;
		logic [DW:0]       i1;
		logic              gfound;
		logic [COST_W-1:0] gval;
		logic [PATH_W-1:0] m;
		p1 = {1'b0, pd};
		for (int s = 0; s < 2; s++) begin
			gfound = 1'b0;
			gval   = '0;
			for (int k = 2; k >= 0; k--) begin
				i1 = {1'b0, ti_q[s][k]};
				if (tvld_q[s][k] && !(i1 == p1 || i1 == p1 + 1'b1 || i1 + 1'b1 == p1)) begin
					gfound = 1'b1;
					gval   = tv_q[s][k];
				end
			end
			m = PATH_W'(w1_q[s]);
			if (pd != '0 && PATH_W'(w0_q[s]) + PATH_W'(cfg.penalty_small) < m) begin
				m = PATH_W'(w0_q[s]) + PATH_W'(cfg.penalty_small);
			end
			if (rd_vld_s1 && PATH_W'(nv[s]) + PATH_W'(cfg.penalty_small) < m) begin
				m = PATH_W'(nv[s]) + PATH_W'(cfg.penalty_small);
			end
			if (gfound && PATH_W'(gval) + PATH_W'(cfg.penalty_large) < m) begin
				m = PATH_W'(gval) + PATH_W'(cfg.penalty_large);
			end
			path[s] = m;
		end
		agg = ((col_q != '0) ? path[0] : '0) + (!first_q ? path[1] : '0);
	end

	logic              vld_s1;
	logic [PATH_W-1:0] agg_s1;
	logic [DW-1:0]     pd_s1;
	logic [PATH_W-1:0] bestv_q;
	logic [DW-1:0]     best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= proc;
		end
	end

	always_ff @(posedge clk) begin
		agg_s1 <= agg;
		pd_s1  <= pd;
		if (cmd.agg && cmd.cnt >= CNT_W'(1)) begin
			for (int s = 0; s < 2; s++) begin
				w0_q[s] <= w1_q[s];
				w1_q[s] <= nv[s];
			end
		end
		if (proc) begin
			lcost_q[pd] <= cost;
		end
		if (cmd.agg && vld_s1 && (pd_s1 == '0 || agg_s1 < bestv_q)) begin
			bestv_q <= agg_s1;
			best_q  <= pd_s1;
		end
	end

	sdm_ram #(
		.WIDTH (COST_W),
		.DEPTH (DEPTH)
	) u_row_ram (
		.clk   (clk),
		.we    (proc),
		.waddr ({col_q, pd}),
		.wdata (cost),
		.raddr ({col_q, cnt_d}),
		.rdata (ram_rdata)
	);

	// restoring divide of best*255 by the range, one quotient bit a step
	logic [NW-1:0] rem_q;
	logic [NW-1:0] dv_q;
	logic [7:0]    q_q;

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			if (cmd.cnt == '0) begin
				rem_q <= (NW'(best_q) << 8) - NW'(best_q);
				dv_q  <= NW'(rng) << (DIV_STEPS - 1);
				q_q   <= '0;
			end else begin
				if (rem_q >= dv_q) begin
					rem_q <= rem_q - dv_q;
					q_q   <= {q_q[6:0], 1'b1};
				end else begin
					q_q <= {q_q[6:0], 1'b0};
				end
				dv_q <= dv_q >> 1;
			end
		end
		if (cmd.out_load) begin
			res.disparity_level <= q_q;
			res.disp_idx        <= 5'(best_q);
		end
	end

endmodule

FILE: src/stereo_disparity_matcher_core.sv
`timescale 1ns / 1ps
// Top level of the stereo disparity matcher: APB register file, sequencer, datapath.
// Depends on sdm_pkg, sdm_ctrl, sdm_datapath.

// One left/right pixel pair is taken per request and one disparity result is
// returned for it. The block works on one request at a time: the row cost
// memory is passed twice through its single read port, once to collect the
// three lowest neighbour costs and once to aggregate each disparity, and the
// output scaling runs through an 8-step divider. A finished result waits in
// the output register while the next request is already taken. The row cost
// memory holds MAX_WIDTH columns of 2**clog2(MAX_DISPARITY) entries and
// needs no clearing.
module stereo_disparity_matcher_core import sdm_pkg::*; #(
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_DISPARITY = 32,
	parameter int MAX_CHANNELS  = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  pix_t              pix,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= RST_IMAGE_WIDTH;
			cfg_q.disp_range    <= RST_DISP_RANGE;
			cfg_q.penalty_small <= RST_PENALTY_SMALL;
			cfg_q.penalty_large <= RST_PENALTY_LARGE;
			cfg_q.channel_count <= RST_CHANNEL_COUNT;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= pwdata[10:0];
				REG_DISP_RANGE:    cfg_q.disp_range    <= pwdata[5:0];
				REG_PENALTY_SMALL: cfg_q.penalty_small <= pwdata[7:0];
				REG_PENALTY_LARGE: cfg_q.penalty_large <= pwdata[7:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IMAGE_WIDTH:   prdata = 32'(cfg_q.image_width);
			REG_DISP_RANGE:    prdata = 32'(cfg_q.disp_range);
			REG_PENALTY_SMALL: prdata = 32'(cfg_q.penalty_small);
			REG_PENALTY_LARGE: prdata = 32'(cfg_q.penalty_large);
			REG_CHANNEL_COUNT: prdata = 32'(cfg_q.channel_count);
			default:           prdata = '0;
		endcase
	end

	sdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.pix_stall (pix_stall),
		.res_valid (res_valid),
		.cmd       (cmd)
	);

	sdm_datapath #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_DISPARITY (MAX_DISPARITY),
		.MAX_CHANNELS  (MAX_CHANNELS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.pix    (pix),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

endmodule

FILE: src/sdm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the disparity matcher, bound to the top level.
// Depends on sdm_pkg and stereo_disparity_matcher_core.
module sdm_checker import sdm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              pix_valid,
	input logic              pix_stall,
	input pix_t              pix,
	input logic              res_valid,
	input logic              res_stall,
	input res_t              res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pix))
		else $error("request changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall |=> pix_stall)
		else $error("request taken while a previous one is in progress");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_stall) |-> $past(pix_valid))
		else $error("busy without a request");

endmodule

bind stereo_disparity_matcher_core sdm_checker u_sdm_checker (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for stereo_disparity_matcher_core: random and directed pixel streams,
// register sweeps over APB, with a cost-aggregation predictor held in a small scoreboard class.
// Depends on sdm_pkg and the RTL of the block.
module testbench;
	import sdm_pkg::*;

	class disparity_scoreboard;
		int unsigned width_reg, range_reg, psmall, plarge, chans;
		int unsigned rhist[32];
		int unsigned left_cost[32];
		int unsigned upper_cost[1024][32];
		int unsigned col;
		bit          first_row;
		res_t        pending_res[$];
		int          mismatches;
		int          results_seen;

		function void clear();
			width_reg = 1024; range_reg = 25; psmall = 10; plarge = 120; chans = 3;
			foreach (rhist[i]) rhist[i] = 0;
			foreach (left_cost[i]) left_cost[i] = 0;
			col = 0; first_row = 1;
			mismatches = 0; results_seen = 0;
		endfunction

		function void set_reg(int idx, int unsigned v);
			case (idx)
				REG_IMAGE_WIDTH:   width_reg = v & 11'h7ff;
				REG_DISP_RANGE:    range_reg = v & 6'h3f;
				REG_PENALTY_SMALL: psmall = v & 8'hff;
				REG_PENALTY_LARGE: plarge = v & 8'hff;
				REG_CHANNEL_COUNT: chans = v & 2'h3;
				default: ;
			endcase
		endfunction

		function int unsigned penalty(int unsigned a, int unsigned b);
			int unsigned df;
			df = a > b ? a - b : b - a;
			if (df == 0) return 0;
			return df == 1 ? psmall : plarge;
		endfunction

		function int unsigned absdiff(logic [7:0] a, logic [7:0] b);
			return a > b ? a - b : b - a;
		endfunction

		function void note_input(pix_t p);
			int unsigned w, rng, nch, x, best, bestv, agg, m, t, sad;
			int unsigned cost[32];
			logic [23:0] rp;
			logic [23:0] lp;
			logic [23:0] rnow;
			res_t r;
			w = width_reg; rng = range_reg; nch = chans;
			if (w < 1) w = 1;
			if (w > 1024) w = 1024;
			if (rng < 1) rng = 1;
			if (rng > 32) rng = 32;
			if (nch < 1) nch = 1;
			if (p.frame_start) begin
				col = 0; first_row = 1;
			end
			if (col >= 1024) col = 0;
			x = col;
			lp = {p.left_c2, p.left_c1, p.left_c0};
			rnow = {p.right_c2, p.right_c1, p.right_c0};
			for (int d = 0; d < rng; d++) begin
				rp = d == 0 ? rnow : 24'(rhist[d-1]);
				sad = 0;
				for (int c = 0; c < nch; c++)
					sad += (d <= x) ? absdiff(lp[8*c +: 8], rp[8*c +: 8]) : 255;
				cost[d] = sad;
			end
			best = 0; bestv = 0;
			for (int d = 0; d < rng; d++) begin
				agg = 0;
				if (x > 0) begin
					m = left_cost[d];
					for (int pd = 0; pd < rng; pd++) begin
						t = left_cost[pd] + penalty(d, pd);
						if (t < m) m = t;
					end
					agg += m;
				end
				if (!first_row) begin
					m = upper_cost[x][d];
					for (int pd = 0; pd < rng; pd++) begin
						t = upper_cost[x][pd] + penalty(d, pd);
						if (t < m) m = t;
					end
					agg += m;
				end
				if (d == 0 || agg < bestv) begin
					bestv = agg; best = d;
				end
			end
			for (int d = 0; d < rng; d++) begin
				left_cost[d] = cost[d];
				upper_cost[x][d] = cost[d];
			end
			for (int d = 31; d > 0; d--) rhist[d] = rhist[d-1];
			rhist[0] = rnow;
			if (x + 1 >= w) begin
				col = 0; first_row = 0;
			end else
				col = x + 1;
			r.disparity_level = 8'((best * 255 / rng) & 8'hff);
			r.disp_idx        = best[4:0];
			pending_res.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t exp_r;
			results_seen++;
			if (pending_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: level %0d disparity %0d",
						got.disparity_level, got.disp_idx);
				return;
			end
			exp_r = pending_res.pop_front();
			if (got.disparity_level !== exp_r.disparity_level ||
					got.disp_idx !== exp_r.disp_idx) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: expected level %0d disp %0d, got level %0d disp %0d",
						results_seen, exp_r.disparity_level, exp_r.disp_idx,
						got.disparity_level, got.disp_idx);
			end
		endfunction

		function int outstanding();
			return pending_res.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              pix_valid;
	logic              pix_stall;
	pix_t              pix;
	logic              res_valid;
	logic              res_stall;
	res_t              res;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	disparity_scoreboard sb;
	bit    long_hold_req;
	int    items_sent;
	int    phases_run;
	int    burst_left;

	stereo_disparity_matcher_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall) sb.note_input(pix);
		if (arst_n && res_valid && !res_stall) sb.check_result(res);
	end

	// receiver back-pressure: changing mix of free flow, light and heavy stalling, and long holds on request
	initial begin
		int mode, span;
		res_stall = 0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				res_stall <= 1;
				repeat (600) @(posedge clk);
				long_hold_req = 0;
			end
			mode = $urandom_range(0, 2);
			span = $urandom_range(20, 300);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: res_stall <= 0;
					1: res_stall <= ($urandom_range(0, 3) == 0);
					default: res_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	task automatic apb_write(logic [2:0] idx, logic [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(idx) << 2; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, v);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic drain();
		pix_valid <= 0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic configure(int unsigned w, int unsigned rng, int unsigned ps,
			int unsigned pl, int unsigned ch);
		drain();
		apb_write(REG_IMAGE_WIDTH, w);
		apb_write(REG_DISP_RANGE, rng);
		apb_write(REG_PENALTY_SMALL, ps);
		apb_write(REG_PENALTY_LARGE, pl);
		apb_write(REG_CHANNEL_COUNT, ch);
		phases_run++;
	endtask

	task automatic send_pixel(pix_t p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
			if (gap > 0) begin
				pix_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pix_valid <= 1;
		pix <= p;
		do @(posedge clk); while (pix_stall);
		items_sent++;
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pix_t rand_pixel(bit fs);
		pix_t p;
		p.left_c0 = rand_byte(); p.left_c1 = rand_byte(); p.left_c2 = rand_byte();
		p.right_c0 = rand_byte(); p.right_c1 = rand_byte(); p.right_c2 = rand_byte();
		p.frame_start = fs;
		return p;
	endfunction

	task automatic run_phase(int n, bit with_hold);
		pix_t p;
		for (int i = 0; i < n; i++) begin
			p = rand_pixel(i == 0 || $urandom_range(0, 60) == 0);
			if (with_hold && i == n / 3) long_hold_req = 1;
			if (with_hold && i == 2 * n / 3) drain();
			send_pixel(p);
		end
	endtask

	initial begin
		pix_t p;
		int   n;
		sb = new();
		sb.clear();
		arst_n = 0; pix_valid = 0; pix = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		long_hold_req = 0; items_sent = 0; phases_run = 0; burst_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset settings, then extreme pixels on a narrow image
		p = '0; p.frame_start = 1;
		send_pixel(p);
		p = '1;
		send_pixel(p);
		p = '0;
		send_pixel(p);
		configure(4, 32, 0, 255, 3);
		for (int i = 0; i < 12; i++) begin
			p = '0;
			if (i[0]) begin
				p.left_c0 = 8'hff; p.left_c1 = 8'hff; p.left_c2 = 8'hff;
			end else begin
				p.right_c0 = 8'hff; p.right_c1 = 8'hff; p.right_c2 = 8'hff;
			end
			p.frame_start = (i == 0) || (i == 9);
			send_pixel(p);
		end
		configure(0, 0, 255, 0, 0);
		run_phase(8, 0);

		// register extremes and out-of-range codes
		configure(2047, 63, 255, 255, 3);
		run_phase(60, 0);
		configure(1, 1, 0, 0, 1);
		run_phase(40, 0);
		configure(3, 2, 1, 2, 2);
		run_phase(60, 1);
		configure(1024, 25, 10, 120, 3);
		run_phase(40, 0);

		while (items_sent < 1450) begin
			n = $urandom_range(60, 160);
			configure($urandom_range(0, 7) == 0 ? $urandom_range(1, 1100) : $urandom_range(1, 40),
				$urandom_range(0, 63), $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 3));
			run_phase(n, $urandom_range(0, 5) == 0);
		end
		drain();

		$display("%0d pixels over %0d register settings, %0d results checked",
			items_sent, phases_run, sb.results_seen);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.outstanding());
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
